@@ rtl/core/one_shot_key_command_gate_defines.svh @@
// ----------------------------------------------------------------------------
// One-shot key command gate: assertion macros
// Shared concurrent assertion forms, clocked on clk with the asynchronous
// active-low reset disabling the check.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_KEY_COMMAND_GATE_DEFINES_SVH
`define ONE_SHOT_KEY_COMMAND_GATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OKCG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one_shot_key_command_gate: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OKCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one_shot_key_command_gate: next-cycle check failed");

`endif

@@ rtl/core/okcg_pkg.sv @@
// ----------------------------------------------------------------------------
// okcg_pkg
// Types, codes and constant tables shared by the one-shot key command gate.
// ----------------------------------------------------------------------------
package okcg_pkg;

    localparam int NUM_KEYS_DEF  = 4;
    localparam int MSG_LIMIT_DEF = 255;
    localparam int NUM_WORDS     = 6;

    // The generator state is 31 bits wide, so only the low 31 bits matter.
    localparam logic [30:0] LCG_MUL = 31'd1103515245;
    localparam logic [30:0] LCG_ADD = 31'd12345;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [7:0] {
        PH_START      = 8'b0000_0001,
        PH_KEY_LEAD   = 8'b0000_0010,
        PH_KEY        = 8'b0000_0100,
        PH_GAP        = 8'b0000_1000,
        PH_WORD       = 8'b0001_0000,
        PH_DONE       = 8'b0010_0000,
        PH_NUL_EMPTY  = 8'b0100_0000,
        PH_NUL_KEY    = 8'b1000_0000
    } parse_phase_t;

    typedef enum logic [2:0] {
        VERD_OK        = 3'd0,
        VERD_NO_KEY    = 3'd1,
        VERD_BAD_KEY   = 3'd2,
        VERD_NO_CMD    = 3'd3,
        VERD_UNKNOWN   = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_BEACON  = 3'd1,
        ACT_TXOFF   = 3'd2,
        ACT_TXON    = 3'd3,
        ACT_DIGIOFF = 3'd4,
        ACT_DIGION  = 3'd5,
        ACT_STATUS  = 3'd6
    } action_t;

    localparam logic KIND_KEY     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    // Command words, upper case, padded with zero bytes.
    localparam logic [7:0] WORD_TEXT [NUM_WORDS][8] = '{
        '{8'h42, 8'h45, 8'h41, 8'h43, 8'h4F, 8'h4E, 8'h00, 8'h00},
        '{8'h54, 8'h58, 8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00},
        '{8'h54, 8'h58, 8'h4F, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h49, 8'h47, 8'h49, 8'h4F, 8'h46, 8'h46, 8'h00},
        '{8'h44, 8'h49, 8'h47, 8'h49, 8'h4F, 8'h4E, 8'h00, 8'h00},
        '{8'h53, 8'h54, 8'h41, 8'h54, 8'h55, 8'h53, 8'h00, 8'h00}
    };

    localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{3'd6, 3'd5, 3'd4, 3'd7, 3'd6, 3'd6};

    typedef struct packed {
        logic        command;
        logic [7:0]  msg_byte;
        logic        last_byte;
        logic [31:0] seed;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  key_index;
        logic [31:0] key_value;
        logic        last_key;
        logic [2:0]  verdict;
        logic [2:0]  action;
        logic        tx_flag;
        logic        digi_flag;
    } out_item_t;

    typedef struct packed {
        parse_phase_t          phase;
        logic [31:0]           hex_accum;
        logic [NUM_WORDS-1:0]  cands;
    } parse_status_t;

endpackage

@@ rtl/core/okcg_lcg.sv @@
// ----------------------------------------------------------------------------
// okcg_lcg
// 31-bit linear congruential generator: one multiply-add step per cycle while step is high.
// ----------------------------------------------------------------------------
module okcg_lcg (
    input  logic        clk,
    input  logic        load,
    input  logic [30:0] seed,
    input  logic        step,
    output logic [30:0] state
);

    logic [30:0] state_reg;
    logic [30:0] state_next;
    logic [30:0] prod;

    // Only the low 31 bits of the product survive the truncation to prod.
    assign prod = state_reg * okcg_pkg::LCG_MUL;

    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            state_next = seed;
        end
        else if (step)
        begin
            state_next = prod + okcg_pkg::LCG_ADD;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

@@ rtl/core/okcg_parser.sv @@
// ----------------------------------------------------------------------------
// okcg_parser
// Byte-serial tokenizer: hex key token followed by a case-blind command word.
// ----------------------------------------------------------------------------
module okcg_parser #(
    parameter int MSG_LIMIT = okcg_pkg::MSG_LIMIT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_en,
    input  logic [7:0]             msg_byte,
    input  logic                   last_byte,
    input  logic                   clear,
    output okcg_pkg::parse_status_t status
);

    localparam int CW = $clog2(MSG_LIMIT + 1);

    okcg_pkg::parse_phase_t            phase_reg, phase_next;
    logic [31:0]                       accum_reg, accum_next;
    logic                              stopped_reg, stopped_next;
    logic [okcg_pkg::NUM_WORDS-1:0]    cands_reg, cands_next;
    logic [2:0]                        pos_reg, pos_next;
    logic [CW-1:0]                     count_reg, count_next;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b0, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    always_comb
    begin
        logic [7:0] c;
        logic [7:0] uc;
        logic [4:0] d;
        logic       counted;
        logic       do_key;
        logic       do_cmd;
        logic       do_fin;

        c            = msg_byte;
        uc           = msg_byte;
        d            = 5'd0;
        counted      = byte_en && (count_reg < CW'(MSG_LIMIT));
        do_key       = 1'b0;
        do_cmd       = 1'b0;
        do_fin       = 1'b0;
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        stopped_next = stopped_reg;
        cands_next   = cands_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;

        if (counted)
        begin
            count_next = count_reg + CW'(1);
            case (phase_reg)
                okcg_pkg::PH_START:
                begin
                    if (c == okcg_pkg::CHAR_NUL)
                    begin
                        phase_next = okcg_pkg::PH_NUL_EMPTY;
                    end
                    else if (c != okcg_pkg::CHAR_SPACE)
                    begin
                        phase_next = okcg_pkg::PH_KEY_LEAD;
                        do_key     = 1'b1;
                    end
                end
                okcg_pkg::PH_KEY_LEAD, okcg_pkg::PH_KEY:
                begin
                    if (c == okcg_pkg::CHAR_NUL)
                    begin
                        phase_next = okcg_pkg::PH_NUL_KEY;
                    end
                    else if (c == okcg_pkg::CHAR_SPACE)
                    begin
                        phase_next = okcg_pkg::PH_GAP;
                    end
                    else
                    begin
                        do_key = 1'b1;
                    end
                end
                okcg_pkg::PH_GAP:
                begin
                    if (c == okcg_pkg::CHAR_NUL)
                    begin
                        phase_next = okcg_pkg::PH_NUL_KEY;
                    end
                    else if (c != okcg_pkg::CHAR_SPACE)
                    begin
                        phase_next = okcg_pkg::PH_WORD;
                        cands_next = '1;
                        pos_next   = 3'd0;
                        do_cmd     = 1'b1;
                    end
                end
                okcg_pkg::PH_WORD:
                begin
                    if (c == okcg_pkg::CHAR_NUL || c == okcg_pkg::CHAR_SPACE)
                    begin
                        do_fin = 1'b1;
                    end
                    else
                    begin
                        do_cmd = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Control whitespace is skipped only ahead of the first key character.
        if (do_key)
        begin
            if (!(phase_next == okcg_pkg::PH_KEY_LEAD && c inside {[8'd9:8'd13]}))
            begin
                phase_next = okcg_pkg::PH_KEY;
                if (!stopped_next)
                begin
                    d = hex_digit(c);
                    if (d[4])
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        accum_next = {accum_next[27:0], d[3:0]};
                    end
                end
            end
        end

        if (do_cmd)
        begin
            uc = (c inside {[8'h61:8'h7A]}) ? c - 8'h20 : c;
            for (int w = 0; w < okcg_pkg::NUM_WORDS; w++)
            begin
                if (pos_next >= okcg_pkg::WORD_LEN[w] ||
                    okcg_pkg::WORD_TEXT[w][pos_next] != uc)
                begin
                    cands_next[w] = 1'b0;
                end
            end
            if (pos_next < 3'd7)
            begin
                pos_next = pos_next + 3'd1;
            end
        end

        // A word still open when the message closes ends there as well.
        if (do_fin || (byte_en && last_byte && phase_next == okcg_pkg::PH_WORD))
        begin
            for (int w = 0; w < okcg_pkg::NUM_WORDS; w++)
            begin
                if (okcg_pkg::WORD_LEN[w] != pos_next)
                begin
                    cands_next[w] = 1'b0;
                end
            end
            phase_next = okcg_pkg::PH_DONE;
        end

        if (clear)
        begin
            phase_next   = okcg_pkg::PH_START;
            accum_next   = 32'd0;
            stopped_next = 1'b0;
            cands_next   = '1;
            pos_next     = 3'd0;
            count_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= okcg_pkg::PH_START;
            accum_reg   <= 32'd0;
            stopped_reg <= 1'b0;
            cands_reg   <= '1;
            pos_reg     <= 3'd0;
            count_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            stopped_reg <= stopped_next;
            cands_reg   <= cands_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
        end
    end

    assign status.phase     = phase_reg;
    assign status.hex_accum = accum_reg;
    assign status.cands     = cands_reg;

endmodule

@@ rtl/core/one_shot_key_command_gate.sv @@
// ----------------------------------------------------------------------------
// One-shot key command gate
// Generates one-shot keys from a seed and gates remote text commands on them.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_stall | okcg_pkg::in_item_t
//   rsp     | out       | rsp_valid/rsp_stall | okcg_pkg::out_item_t
//
// A message byte is taken while the sequencer idles; the closing byte adds a scan
// of the NUM_KEYS key slots and a verdict state. A generate item walks ST_GEN_A,
// ST_GEN_B and ST_GEN_EMIT for each key: two steps of the shared multiply-add
// generator and one output state per key.
// Reset is asynchronous; there is no clearing pass after it.
// A stalled result holds the sequencer, and req_stall stays high until it idles.
// ----------------------------------------------------------------------------
module one_shot_key_command_gate #(
    parameter int NUM_KEYS  = okcg_pkg::NUM_KEYS_DEF,
    parameter int MSG_LIMIT = okcg_pkg::MSG_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  okcg_pkg::in_item_t  req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output okcg_pkg::out_item_t rsp_data
);

    `include "one_shot_key_command_gate_defines.svh"

    localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KIW-1:0] LAST_IDX = KIW'(NUM_KEYS - 1);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b00_0001,
        ST_GEN_A    = 6'b00_0010,
        ST_GEN_B    = 6'b00_0100,
        ST_GEN_EMIT = 6'b00_1000,
        ST_SCAN     = 6'b01_0000,
        ST_VERDICT  = 6'b10_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [KIW-1:0]           idx_reg, idx_next;
    logic                     found_reg, found_next;
    logic [KIW-1:0]           match_reg, match_next;
    logic [15:0]              a_reg, a_next;
    logic [31:0]              key_store_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0]      key_valid_reg, key_valid_next;
    logic                     tx_reg, tx_next;
    logic                     digi_reg, digi_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    okcg_pkg::out_item_t      rsp_data_reg, rsp_data_next;

    logic                     req_accept;
    logic                     rsp_free;
    logic                     lcg_load;
    logic                     lcg_step;
    logic [30:0]              lcg_state;
    logic                     key_write;
    logic [31:0]              new_key;
    logic                     parse_clear;
    okcg_pkg::parse_status_t  pstat;
    okcg_pkg::verdict_t       verdict_v;
    okcg_pkg::action_t        action_v;
    logic [KIW+1:0]           idx_ext;
    logic [KIW+1:0]           match_ext;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign lcg_load   = req_accept && (req_data.command == okcg_pkg::CMD_GENERATE);
    assign new_key    = {a_reg, 16'h0000} | {1'b0, lcg_state};
    assign idx_ext    = {2'b00, idx_reg};
    assign match_ext  = {2'b00, match_reg};

    okcg_lcg u_lcg (
        .clk   (clk),
        .load  (lcg_load),
        .seed  (req_data.seed[30:0]),
        .step  (lcg_step),
        .state (lcg_state)
    );

    okcg_parser #(
        .MSG_LIMIT (MSG_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (req_accept && (req_data.command == okcg_pkg::CMD_BYTE)),
        .msg_byte  (req_data.msg_byte),
        .last_byte (req_data.last_byte),
        .clear     (parse_clear),
        .status    (pstat)
    );

    // Verdict from the finished parse and the result of the key scan.
    always_comb
    begin
        action_v = okcg_pkg::ACT_NONE;
        if (pstat.phase == okcg_pkg::PH_START || pstat.phase == okcg_pkg::PH_NUL_EMPTY)
        begin
            verdict_v = okcg_pkg::VERD_NO_KEY;
        end
        else if (!found_reg)
        begin
            verdict_v = okcg_pkg::VERD_BAD_KEY;
        end
        else if (pstat.phase != okcg_pkg::PH_DONE)
        begin
            verdict_v = okcg_pkg::VERD_NO_CMD;
        end
        else if (pstat.cands == '0)
        begin
            verdict_v = okcg_pkg::VERD_UNKNOWN;
        end
        else
        begin
            verdict_v = okcg_pkg::VERD_OK;
            for (int w = okcg_pkg::NUM_WORDS - 1; w >= 0; w--)
            begin
                if (pstat.cands[w])
                begin
                    action_v = okcg_pkg::action_t'(3'(w + 1));
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        match_next     = match_reg;
        a_next         = a_reg;
        key_valid_next = key_valid_reg;
        tx_next        = tx_reg;
        digi_next      = digi_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        lcg_step       = 1'b0;
        key_write      = 1'b0;
        parse_clear    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (req_data.command == okcg_pkg::CMD_GENERATE)
                    begin
                        idx_next   = '0;
                        state_next = ST_GEN_A;
                    end
                    else if (req_data.last_byte)
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        match_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_GEN_A:
            begin
                lcg_step   = 1'b1;
                state_next = ST_GEN_B;
            end
            ST_GEN_B:
            begin
                a_next     = lcg_state[15:0];
                lcg_step   = 1'b1;
                state_next = ST_GEN_EMIT;
            end
            ST_GEN_EMIT:
            begin
                if (rsp_free)
                begin
                    key_write               = 1'b1;
                    key_valid_next[idx_reg] = 1'b1;
                    rsp_valid_next          = 1'b1;
                    rsp_data_next.kind      = okcg_pkg::KIND_KEY;
                    rsp_data_next.key_index = idx_ext[1:0];
                    rsp_data_next.key_value = new_key;
                    rsp_data_next.last_key  = (idx_reg == LAST_IDX);
                    rsp_data_next.verdict   = okcg_pkg::VERD_OK;
                    rsp_data_next.action    = okcg_pkg::ACT_NONE;
                    rsp_data_next.tx_flag   = tx_reg;
                    rsp_data_next.digi_flag = digi_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + KIW'(1);
                        state_next = ST_GEN_A;
                    end
                end
            end
            ST_SCAN:
            begin
                // One stored key against the parsed token per cycle; lowest slot wins.
                if (!found_reg && key_valid_reg[idx_reg] &&
                    key_store_reg[idx_reg] == pstat.hex_accum)
                begin
                    found_next = 1'b1;
                    match_next = idx_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_VERDICT;
                end
                else
                begin
                    idx_next = idx_reg + KIW'(1);
                end
            end
            ST_VERDICT:
            begin
                if (rsp_free)
                begin
                    if (verdict_v == okcg_pkg::VERD_OK)
                    begin
                        key_valid_next[match_reg] = 1'b0;
                        case (action_v)
                            okcg_pkg::ACT_TXOFF:   tx_next   = 1'b0;
                            okcg_pkg::ACT_TXON:    tx_next   = 1'b1;
                            okcg_pkg::ACT_DIGIOFF: digi_next = 1'b0;
                            okcg_pkg::ACT_DIGION:  digi_next = 1'b1;
                            default:
                            begin
                            end
                        endcase
                    end
                    rsp_valid_next          = 1'b1;
                    rsp_data_next.kind      = okcg_pkg::KIND_VERDICT;
                    rsp_data_next.key_index =
                        (found_reg && verdict_v != okcg_pkg::VERD_NO_KEY) ?
                        match_ext[1:0] : 2'd0;
                    rsp_data_next.key_value = 32'd0;
                    rsp_data_next.last_key  = 1'b0;
                    rsp_data_next.verdict   = verdict_v;
                    rsp_data_next.action    = action_v;
                    rsp_data_next.tx_flag   = tx_next;
                    rsp_data_next.digi_flag = digi_next;
                    parse_clear             = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            match_reg     <= '0;
            key_valid_reg <= '0;
            tx_reg        <= 1'b1;
            digi_reg      <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            match_reg     <= match_next;
            key_valid_reg <= key_valid_next;
            tx_reg        <= tx_next;
            digi_reg      <= digi_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        rsp_data_reg <= rsp_data_next;
        if (key_write)
        begin
            key_store_reg[idx_reg] <= new_key;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    `OKCG_ASSERT_NEXT(a_gen_starts, clk, rst_n, lcg_load, state_reg == ST_GEN_A)
    `OKCG_ASSERT_SAME(a_ok_has_action, clk, rst_n,
        rsp_valid && rsp_data.kind == okcg_pkg::KIND_VERDICT &&
        rsp_data.verdict == okcg_pkg::VERD_OK,
        rsp_data.action != okcg_pkg::ACT_NONE)
    `OKCG_ASSERT_NEXT(a_key_spent, clk, rst_n,
        state_reg == ST_VERDICT && rsp_free && verdict_v == okcg_pkg::VERD_OK,
        !key_valid_reg[match_reg])

endmodule
